/* hdl/nfa_to_dfa_subset_construction_core_defines.svh */
// Assertion macros shared by the RTL
`ifndef NFA_TO_DFA_SUBSET_CONSTRUCTION_CORE_DEFINES_SVH
`define NFA_TO_DFA_SUBSET_CONSTRUCTION_CORE_DEFINES_SVH

// Check a property on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);

`endif

/* hdl/n2d_pkg.sv */
package n2d_pkg;

    localparam int NFA_STATES     = 26;
    localparam int MAX_DFA_STATES = 64;
    localparam int SET_W          = 26;
    localparam int ROW_W          = 5;
    localparam int IDX_W          = $clog2(NFA_STATES);
    localparam int DFA_IDX_W      = $clog2(MAX_DFA_STATES);
    localparam int DFA_CNT_W      = DFA_IDX_W + 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BUILD = 1'b1;

    typedef logic [SET_W-1:0] set_t;

    typedef struct packed {
        logic             operation;
        logic [ROW_W-1:0] row;
        set_t             on_a;
        set_t             on_b;
        set_t             on_eps;
    } in_item_t;

    typedef struct packed {
        set_t dfa_set;
        set_t next_on_a;
        set_t next_on_b;
        logic overflow;
        logic last;
    } out_item_t;

    // Request from the sequencer to the list unit
    typedef struct packed {
        logic start;
        logic clear;
        set_t set;
    } lookup_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic dropped;
    } lookup_rsp_t;

endpackage

/* hdl/n2d_if.sv */
interface n2d_in_if;
    import n2d_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface n2d_out_if;
    import n2d_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/n2d_list.sv */
// DFA state list: one compare per cycle against stored sets, append if new and room remains
module n2d_list
    import n2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lookup_req_t          req,
    output lookup_rsp_t          rsp,
    input  logic [DFA_IDX_W-1:0] rd_addr,
    output set_t                 rd_data,
    output logic [DFA_CNT_W-1:0] count
);

    set_t mem [MAX_DFA_STATES];
    logic [DFA_CNT_W-1:0] count_reg, count_next;
    logic [DFA_CNT_W-1:0] scan_reg, scan_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 drop_reg, drop_next;
    logic                 wr_en;
    set_t                 key_reg;
    set_t                 cmp_reg;
    logic                 cmp_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (req.clear)
            begin
                mem[0] <= req.set;
            end
            else
            begin
                mem[count_reg[DFA_IDX_W-1:0]] <= key_reg;
            end
        end
        rd_data <= mem[rd_addr];
        cmp_reg <= mem[scan_next[DFA_IDX_W-1:0]];
        if (req.start)
        begin
            key_reg <= req.set;
        end
    end

    // Compare stream: scan index issues reads; data is registered and valid in the next cycle
    always_comb
    begin
        count_next = count_reg;
        scan_next  = scan_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        drop_next  = drop_reg;
        wr_en      = 1'b0;
        if (req.clear)
        begin
            wr_en      = 1'b1;
            count_next = DFA_CNT_W'(1);
            busy_next  = 1'b0;
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            scan_next = '0;
            drop_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (cmp_ok_reg && cmp_reg == key_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (scan_reg >= count_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (count_reg >= DFA_CNT_W'(MAX_DFA_STATES))
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                scan_next = scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            drop_reg   <= 1'b0;
            cmp_ok_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            drop_reg   <= drop_next;
            cmp_ok_reg <= busy_next && !done_next && (scan_next < count_reg);
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.dropped = drop_reg;
    assign count       = count_reg;

endmodule

/* hdl/nfa_to_dfa_subset_construction_core.sv */
// NFA to DFA subset construction over symbols a and b with epsilon moves.
// A load item (operation 0) stores one NFA row. A build item (operation 1)
// first forms each state's epsilon closure by repeated OR-passes over the
// epsilon table (one row per cycle, up to N passes of N rows per state for N
// NFA states), then walks the DFA work list: for each DFA state the two
// successor sets are gathered together one NFA row per cycle, and each is
// looked up in the DFA list one entry per cycle by a shared compare unit.
// The input is not ready during a build. Results come out in discovery
// order, last marked; overflow rises once a new set finds the 64-entry list full.
`include "nfa_to_dfa_subset_construction_core_defines.svh"
module nfa_to_dfa_subset_construction_core
    import n2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    n2d_in_if.sink     in_ch,
    n2d_out_if.source  out_ch
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CL_ROW = 4'd1;
    localparam logic [3:0] S_CL_END = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_FETCH  = 4'd4;
    localparam logic [3:0] S_CUR    = 4'd5;
    localparam logic [3:0] S_MOVE   = 4'd6;
    localparam logic [3:0] S_LOOKA  = 4'd7;
    localparam logic [3:0] S_WAITA  = 4'd8;
    localparam logic [3:0] S_LOOKB  = 4'd9;
    localparam logic [3:0] S_WAITB  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    set_t tab_a [NFA_STATES];
    set_t tab_b [NFA_STATES];
    set_t tab_e [NFA_STATES];
    set_t clo   [NFA_STATES];

    logic [3:0]           state_reg, state_next;
    logic [4:0]           cnt_reg;
    logic [IDX_W-1:0]     n_max;
    set_t                 mask;
    logic [IDX_W-1:0]     j_reg, j_next, i_reg, i_next;
    set_t                 acc_reg, acc_next, acc2_reg, acc2_next;
    set_t                 cur_reg, cur_next;
    set_t                 na_reg, na_next;
    logic                 over_reg, over_next;
    logic [DFA_CNT_W-1:0] head_reg, head_next;
    logic                 ov_reg, ov_next;
    out_item_t            out_reg, out_next;
    lookup_req_t          req;
    lookup_rsp_t          rsp;
    set_t                 list_rd;
    logic [DFA_CNT_W-1:0] list_cnt;
    set_t                 ta, tb, cl_or_a, cl_or_b;

    always_comb
    begin
        if (cnt_reg == 5'd0)
        begin
            n_max = '0;
        end
        else if (32'(cnt_reg) > NFA_STATES)
        begin
            n_max = IDX_W'(NFA_STATES - 1);
        end
        else
        begin
            n_max = IDX_W'(cnt_reg - 5'd1);
        end
    end

    always_comb
    begin
        for (int k = 0; k < SET_W; k++)
        begin
            mask[k] = (k <= int'(n_max));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.operation == OP_LOAD
            && 32'(in_ch.data.row) < NFA_STATES)
        begin
            tab_a[in_ch.data.row[IDX_W-1:0]] <= in_ch.data.on_a;
            tab_b[in_ch.data.row[IDX_W-1:0]] <= in_ch.data.on_b;
            tab_e[in_ch.data.row[IDX_W-1:0]] <= in_ch.data.on_eps;
        end
        if (state_reg == S_CL_END && acc_reg == acc2_reg)
        begin
            clo[j_reg] <= acc_reg;
        end
    end

    // Closure-expanded targets of row i for the move step
    always_comb
    begin
        ta      = tab_a[i_reg] & mask;
        tb      = tab_b[i_reg] & mask;
        cl_or_a = '0;
        cl_or_b = '0;
        for (int t = 0; t < NFA_STATES; t++)
        begin
            if (ta[t])
            begin
                cl_or_a = cl_or_a | clo[t];
            end
            if (tb[t])
            begin
                cl_or_b = cl_or_b | clo[t];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        acc_next    = acc_reg;
        acc2_next   = acc2_reg;
        cur_next    = cur_reg;
        na_next     = na_reg;
        over_next   = over_reg;
        head_next   = head_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        req         = '0;
        if (out_ch.valid && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.data.operation == OP_BUILD)
                begin
                    state_next = S_CL_ROW;
                    j_next     = '0;
                    i_next     = '0;
                    acc_next   = '0;
                    acc_next[0] = 1'b1;
                    acc2_next  = acc_next;
                    over_next  = 1'b0;
                end
            end
            S_CL_ROW:
            begin
                if (acc_reg[i_reg])
                begin
                    acc2_next = acc2_reg | (tab_e[i_reg] & mask);
                end
                if (i_reg == n_max)
                begin
                    state_next = S_CL_END;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_CL_END:
            begin
                i_next = '0;
                if (acc_reg != acc2_reg)
                begin
                    acc_next   = acc2_reg;
                    state_next = S_CL_ROW;
                end
                else if (j_reg == n_max)
                begin
                    state_next = S_START;
                end
                else
                begin
                    j_next         = j_reg + 1'b1;
                    acc_next       = '0;
                    acc_next[j_next] = 1'b1;
                    acc2_next      = acc_next;
                    state_next     = S_CL_ROW;
                end
            end
            S_START:
            begin
                req.clear  = 1'b1;
                req.set    = clo[0];
                head_next  = '0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_CUR;
            end
            S_CUR:
            begin
                cur_next   = list_rd;
                acc_next   = '0;
                acc2_next  = '0;
                i_next     = '0;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (cur_reg[i_reg])
                begin
                    acc_next  = acc_reg | cl_or_a;
                    acc2_next = acc2_reg | cl_or_b;
                end
                if (i_reg == n_max)
                begin
                    state_next = S_LOOKA;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_LOOKA:
            begin
                req.start  = 1'b1;
                req.set    = acc_reg;
                na_next    = acc_reg;
                state_next = S_WAITA;
            end
            S_WAITA:
            begin
                if (rsp.done)
                begin
                    over_next  = over_reg | rsp.dropped;
                    state_next = S_LOOKB;
                end
            end
            S_LOOKB:
            begin
                req.start  = 1'b1;
                req.set    = acc2_reg;
                state_next = S_WAITB;
            end
            S_WAITB:
            begin
                if (rsp.done)
                begin
                    over_next  = over_reg | rsp.dropped;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next            = 1'b1;
                    out_next.dfa_set   = cur_reg & mask;
                    out_next.next_on_a = na_reg;
                    out_next.next_on_b = acc2_reg;
                    out_next.overflow  = over_reg;
                    out_next.last      = (head_reg + 1'b1) >= list_cnt;
                    head_next          = head_reg + 1'b1;
                    state_next         = ((head_reg + 1'b1) >= list_cnt) ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 5'd1;
            head_reg  <= '0;
            ov_reg    <= 1'b0;
            over_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            ov_reg    <= ov_next;
            over_reg  <= over_next;
            if (cfg_we)
            begin
                cnt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        i_reg    <= i_next;
        acc_reg  <= acc_next;
        acc2_reg <= acc2_next;
        cur_reg  <= cur_next;
        na_reg   <= na_next;
        out_reg  <= out_next;
    end

    n2d_list u_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (head_next[DFA_IDX_W-1:0]),
        .rd_data (list_rd),
        .count   (list_cnt)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = out_reg;

    `ASSERT_CLK(a_busy_not_ready, clk, rst_n,
        !(state_reg != S_IDLE && in_ch.ready), "ready while building")
    `ASSERT_NEXT(a_list_done, clk, rst_n, state_reg == S_LOOKA,
        rsp.busy, "list lookup did not start")
    `ASSERT_CLK(a_head_bound, clk, rst_n,
        !(state_reg == S_EMIT && head_reg >= list_cnt), "emit past list end")

endmodule
